// ===== hdl/spa_pkg.sv =====
// Shared constants, types and codes of the slot pool allocator.
package spa_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int SLOT_W    = 6;
  localparam int CFG_W     = 7;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] MAX_POOL_RESET = 7'd64;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT   = 2'd0,
    REQ_GET    = 2'd1,
    REQ_RETURN = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_POPPED   = 3'd0,
    STAT_CREATED  = 3'd1,
    STAT_REUSED   = 3'd2,
    STAT_RETURNED = 3'd3,
    STAT_REJECTED = 3'd4,
    STAT_NONE     = 3'd5,
    STAT_INIT     = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_SIZE = 1'b0,
    REG_MAX_POOL  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_state_t;

  // Port of one link memory: read address plus one write.
  typedef struct packed {
    idx_t rd_addr;
    logic we;
    idx_t wr_addr;
    idx_t wr_data;
  } link_port_t;

  // Port of the free stack: as a link port, plus a clear of all entries.
  typedef struct packed {
    idx_t rd_addr;
    logic we;
    idx_t wr_addr;
    idx_t wr_data;
    logic clear;
  } stack_port_t;

endpackage

// ===== hdl/spa_if.sv =====
// Request and result channel interfaces of the slot pool allocator.
interface spa_req_if;
  logic                         valid;
  logic                         ready;
  logic [spa_pkg::REQ_W-1:0]    req_type;
  logic [spa_pkg::SLOT_W-1:0]   slot_in;

  modport source (output valid, output req_type, output slot_in, input ready);
  modport sink (input valid, input req_type, input slot_in, output ready);
endinterface

interface spa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spa_pkg::SLOT_W-1:0]   slot_out;
  logic [spa_pkg::STAT_W-1:0]   status;

  modport source (output valid, output slot_out, output status, input ready);
  modport sink (input valid, input slot_out, input status, output ready);
endinterface

// ===== hdl/slot_pool_allocator_oldest_reuse_top.sv =====
// Top level of the slot pool allocator with oldest-in-use reuse.
//
// The block hands out slot indices of a pool of at most 64 objects. Each request
// on the req channel is an init (build init_size free slots), a get (pop the most
// recently freed slot, else create the next slot, else take back the oldest slot
// in use, else answer with status none) or a return of slot_in. Every request
// yields exactly one result on the rsp channel with the slot and a status code.
// Both channels move a request when valid and ready are high at a rising edge.
// Registers init_size (index 0) and max_pool_size (index 1) are written through
// cfg_we/cfg_idx/cfg_wdata and are meant to change only while the block is idle.
// In the accept cycle the free stack and the two link memories are read; in the
// next cycle the read data is used, the memories are written back and the result
// register is loaded. Because those memories are read and then written, no new
// request is accepted until the previous one has been carried out.
// The result register decouples the two sides: a new request is accepted while a
// result is being taken in the same cycle. When the receiver stalls, the result
// holds and no further request is accepted until it is taken.
// Reset (rst, synchronous) empties the pool, clears all in-use flags, sets
// init_size to 0 and max_pool_size to 64. No clearing pass is needed.
module slot_pool_allocator_oldest_reuse_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [spa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [spa_pkg::CFG_W-1:0]     cfg_wdata,
  spa_req_if.sink                       req,
  spa_rsp_if.source                     rsp
);

  spa_pkg::stack_port_t        stack_port;
  spa_pkg::link_port_t         next_port;
  spa_pkg::link_port_t         prev_port;
  spa_pkg::idx_t               stack_rd;
  spa_pkg::idx_t               next_rd;
  spa_pkg::idx_t               prev_rd;
  logic                        res_valid;
  logic [spa_pkg::SLOT_W-1:0]  res_slot;
  spa_pkg::status_t            res_status;

  logic                        out_valid;
  logic [spa_pkg::SLOT_W-1:0]  out_slot;
  logic [spa_pkg::STAT_W-1:0]  out_status;
  logic                        out_space;

  // The result register has room when empty or when it is drained this cycle.
  assign out_space = !out_valid || rsp.ready;

  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .out_space (out_space),
    .stack_port(stack_port),
    .stack_rd  (stack_rd),
    .next_port (next_port),
    .next_rd   (next_rd),
    .prev_port (prev_port),
    .prev_rd   (prev_rd),
    .res_valid (res_valid),
    .res_slot  (res_slot),
    .res_status(res_status)
  );

  // Free slots, stacked; the top sits at free_count - 1.
  spa_stack u_stack (
    .clk    (clk),
    .rst    (rst),
    .port   (stack_port),
    .rd_data(stack_rd)
  );

  // Forward links of the in-use order list, from older to newer.
  spa_ram #(
    .WIDTH(spa_pkg::IDX_W),
    .DEPTH(spa_pkg::SLOTS)
  ) u_next_ram (
    .clk    (clk),
    .we     (next_port.we),
    .wr_addr(next_port.wr_addr),
    .wr_data(next_port.wr_data),
    .rd_addr(next_port.rd_addr),
    .rd_data(next_rd)
  );

  // Backward links of the in-use order list, from newer to older.
  spa_ram #(
    .WIDTH(spa_pkg::IDX_W),
    .DEPTH(spa_pkg::SLOTS)
  ) u_prev_ram (
    .clk    (clk),
    .we     (prev_port.we),
    .wr_addr(prev_port.wr_addr),
    .wr_data(prev_port.wr_data),
    .rd_addr(prev_port.rd_addr),
    .rd_data(prev_rd)
  );

  // Result register. The sequencer only produces a result when there is room.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_slot   <= res_slot;
      out_status <= res_status;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.slot_out = out_slot;
  assign rsp.status   = out_status;

endmodule

// ===== hdl/spa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/spa_stack.sv =====
// Free stack memory; an entry not written since the last init reads as its own index.
module spa_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  spa_pkg::stack_port_t port,
  output spa_pkg::idx_t        rd_data
);

  logic [spa_pkg::SLOTS-1:0] written;
  logic                      hit;
  spa_pkg::idx_t             addr_q;
  spa_pkg::idx_t             ram_q;

  spa_ram #(
    .WIDTH(spa_pkg::IDX_W),
    .DEPTH(spa_pkg::SLOTS)
  ) u_ram (
    .clk    (clk),
    .we     (port.we),
    .wr_addr(port.wr_addr),
    .wr_data(port.wr_data),
    .rd_addr(port.rd_addr),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst || port.clear) begin
      written <= '0;
    end else if (port.we) begin
      written[port.wr_addr] <= 1'b1;
    end
    hit    <= written[port.rd_addr];
    addr_q <= port.rd_addr;
  end

  assign rd_data = hit ? ram_q : addr_q;

endmodule

// ===== hdl/spa_ctrl.sv =====
// Request sequencer and bookkeeping: counts, list ends, in-use flags, memory updates.
module spa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [spa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [spa_pkg::CFG_W-1:0]     cfg_wdata,
  spa_req_if.sink                       req,
  input  logic                          out_space,
  output spa_pkg::stack_port_t          stack_port,
  input  spa_pkg::idx_t                 stack_rd,
  output spa_pkg::link_port_t           next_port,
  input  spa_pkg::idx_t                 next_rd,
  output spa_pkg::link_port_t           prev_port,
  input  spa_pkg::idx_t                 prev_rd,
  output logic                          res_valid,
  output logic [spa_pkg::SLOT_W-1:0]    res_slot,
  output spa_pkg::status_t              res_status
);

  spa_pkg::fsm_state_t         state, state_next;
  logic [spa_pkg::CFG_W-1:0]   init_size;
  logic [spa_pkg::CFG_W-1:0]   max_pool_size;
  spa_pkg::req_t               req_q;
  logic [spa_pkg::SLOT_W-1:0]  slot_q;
  logic [spa_pkg::CNT_W-1:0]   free_count, free_count_next;
  logic [spa_pkg::CNT_W-1:0]   created_count, created_count_next;
  spa_pkg::idx_t               oldest, oldest_next;
  spa_pkg::idx_t               newest, newest_next;
  logic [spa_pkg::SLOTS-1:0]   in_use, in_use_next;

  logic                        accept;
  logic [spa_pkg::CNT_W-1:0]   used;
  logic [spa_pkg::CNT_W-1:0]   limit;
  logic [spa_pkg::CNT_W-1:0]   init_n;
  spa_pkg::idx_t               ret_idx;
  logic                        ret_ok;
  logic                        do_append;
  spa_pkg::idx_t               app_slot;

  assign accept = (state == spa_pkg::FSM_IDLE) && req.valid && out_space;

  always_comb begin
    state_next = state;
    case (state)
      spa_pkg::FSM_IDLE: if (accept) state_next = spa_pkg::FSM_EXEC;
      spa_pkg::FSM_EXEC: state_next = spa_pkg::FSM_IDLE;
      default:           state_next = spa_pkg::FSM_IDLE;
    endcase
  end

  assign req.ready = (state == spa_pkg::FSM_IDLE) && out_space;

  assign used    = created_count - free_count;
  assign limit   = (32'(max_pool_size) < spa_pkg::SLOTS) ?
                   spa_pkg::CNT_W'(max_pool_size) : spa_pkg::CNT_W'(spa_pkg::SLOTS);
  assign init_n  = (32'(init_size) < spa_pkg::SLOTS) ?
                   spa_pkg::CNT_W'(init_size) : spa_pkg::CNT_W'(spa_pkg::SLOTS);
  assign ret_idx = spa_pkg::idx_t'(slot_q);
  assign ret_ok  = (32'(slot_q) < spa_pkg::SLOTS) && in_use[ret_idx];

  always_comb begin
    // Reads are issued in the accept cycle, the link reads straight from the request.
    stack_port.rd_addr = spa_pkg::idx_t'(free_count - spa_pkg::CNT_W'(1));
    next_port.rd_addr  = (spa_pkg::req_t'(req.req_type) == spa_pkg::REQ_GET) ?
                         oldest : spa_pkg::idx_t'(req.slot_in);
    prev_port.rd_addr  = spa_pkg::idx_t'(req.slot_in);

    free_count_next    = free_count;
    created_count_next = created_count;
    oldest_next        = oldest;
    newest_next        = newest;
    in_use_next        = in_use;
    stack_port.we      = 1'b0;
    stack_port.wr_addr = '0;
    stack_port.wr_data = '0;
    stack_port.clear   = 1'b0;
    next_port.we       = 1'b0;
    next_port.wr_addr  = '0;
    next_port.wr_data  = '0;
    prev_port.we       = 1'b0;
    prev_port.wr_addr  = '0;
    prev_port.wr_data  = '0;
    res_valid          = 1'b0;
    res_slot           = '0;
    res_status         = spa_pkg::STAT_NONE;
    do_append          = 1'b0;
    app_slot           = '0;

    if (state == spa_pkg::FSM_EXEC) begin
      res_valid = 1'b1;
      case (req_q)
        spa_pkg::REQ_INIT: begin
          free_count_next    = init_n;
          created_count_next = init_n;
          oldest_next        = '0;
          newest_next        = '0;
          in_use_next        = '0;
          stack_port.clear   = 1'b1;
          res_status         = spa_pkg::STAT_INIT;
        end
        spa_pkg::REQ_GET: begin
          if (free_count != '0) begin
            app_slot        = stack_rd;
            do_append       = 1'b1;
            free_count_next = free_count - spa_pkg::CNT_W'(1);
            res_slot        = spa_pkg::SLOT_W'(stack_rd);
            res_status      = spa_pkg::STAT_POPPED;
          end else if (created_count < limit) begin
            app_slot           = spa_pkg::idx_t'(created_count);
            do_append          = 1'b1;
            created_count_next = created_count + spa_pkg::CNT_W'(1);
            res_slot           = spa_pkg::SLOT_W'(app_slot);
            res_status         = spa_pkg::STAT_CREATED;
          end else if (used != '0) begin
            // Move the oldest slot to the newest end; a single slot stays put.
            app_slot   = oldest;
            res_slot   = spa_pkg::SLOT_W'(oldest);
            res_status = spa_pkg::STAT_REUSED;
            if (used != spa_pkg::CNT_W'(1)) begin
              oldest_next       = next_rd;
              next_port.we      = 1'b1;
              next_port.wr_addr = newest;
              next_port.wr_data = oldest;
              prev_port.we      = 1'b1;
              prev_port.wr_addr = oldest;
              prev_port.wr_data = newest;
              newest_next       = oldest;
            end
          end
        end
        spa_pkg::REQ_RETURN: begin
          if (ret_ok) begin
            in_use_next[ret_idx] = 1'b0;
            if (used != spa_pkg::CNT_W'(1)) begin
              if (ret_idx == oldest) begin
                oldest_next = next_rd;
              end else if (ret_idx == newest) begin
                newest_next = prev_rd;
              end else begin
                next_port.we      = 1'b1;
                next_port.wr_addr = prev_rd;
                next_port.wr_data = next_rd;
                prev_port.we      = 1'b1;
                prev_port.wr_addr = next_rd;
                prev_port.wr_data = prev_rd;
              end
            end
            stack_port.we      = 1'b1;
            stack_port.wr_addr = spa_pkg::idx_t'(free_count);
            stack_port.wr_data = ret_idx;
            free_count_next    = free_count + spa_pkg::CNT_W'(1);
            res_slot           = slot_q;
            res_status         = spa_pkg::STAT_RETURNED;
          end else begin
            res_status = spa_pkg::STAT_REJECTED;
          end
        end
        default: ;
      endcase

      if (do_append) begin
        if (used == '0) begin
          oldest_next = app_slot;
        end else begin
          next_port.we      = 1'b1;
          next_port.wr_addr = newest;
          next_port.wr_data = app_slot;
          prev_port.we      = 1'b1;
          prev_port.wr_addr = app_slot;
          prev_port.wr_data = newest;
        end
        newest_next           = app_slot;
        in_use_next[app_slot] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spa_pkg::FSM_IDLE;
      init_size     <= '0;
      max_pool_size <= spa_pkg::MAX_POOL_RESET;
      free_count    <= '0;
      created_count <= '0;
      oldest        <= '0;
      newest        <= '0;
      in_use        <= '0;
    end else begin
      state         <= state_next;
      free_count    <= free_count_next;
      created_count <= created_count_next;
      oldest        <= oldest_next;
      newest        <= newest_next;
      in_use        <= in_use_next;
      if (cfg_we) begin
        case (spa_pkg::cfg_reg_t'(cfg_idx))
          spa_pkg::REG_INIT_SIZE: init_size     <= cfg_wdata;
          spa_pkg::REG_MAX_POOL:  max_pool_size <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= spa_pkg::req_t'(req.req_type);
      slot_q <= req.slot_in;
    end
  end

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    free_count <= created_count)
    else $error("free count exceeds created count");

  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(used))
    else $error("in-use flags disagree with slot counts");

  a_handout_marked: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_status == spa_pkg::STAT_POPPED ||
                   res_status == spa_pkg::STAT_CREATED ||
                   res_status == spa_pkg::STAT_REUSED)) |=> in_use[$past(app_slot)])
    else $error("handed-out slot not marked in use");

  a_return_cleared: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == spa_pkg::STAT_RETURNED) |=> !in_use[$past(ret_idx)])
    else $error("returned slot still marked in use");

endmodule
